[design/psgq_pkg.sv]
package psgq_pkg;

    localparam int TABLE_SIZE_DEF = 65536;

    typedef enum logic [3:0] {
        S_CLR,
        S_SV_INIT,
        S_SV_TEST,
        S_SV_CHK,
        S_SV_MARK,
        S_IDLE,
        S_DISP,
        S_PRIM_CK,
        S_G_BND,
        S_G_CKP,
        S_G_CKF,
        S_G_CKS,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        PR_SIEVE,
        PR_FIRST,
        PR_P,
        PR_FMP,
        PR_SMP
    } probe_sel_t;

    typedef enum logic [1:0] {
        RES_HOLD,
        RES_PRIM,
        RES_NONE,
        RES_FOUND
    } res_op_t;

    typedef struct packed {
        logic       clr_step;
        logic       sv_init;
        logic       i_inc;
        logic       j_load;
        logic       mark;
        logic       cap;
        logic       p_inc;
        probe_sel_t probe_sel;
        res_op_t    res_op;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic sq_lt_ts;
        logic j_lt_ts;
        logic probe_prime;
        logic p_over;
        logic act;
    } status_t;

endpackage

[design/psgq_ctrl.sv]
module psgq_ctrl
    import psgq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_stall,
    output logic    rsp_valid,
    input  logic    rsp_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_out)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:     if (status.clr_last) state_next = S_SV_INIT;
            S_SV_INIT: state_next = S_SV_TEST;
            S_SV_TEST: state_next = status.sq_lt_ts ? S_SV_CHK : S_IDLE;
            S_SV_CHK:  state_next = status.probe_prime ? S_SV_MARK : S_SV_TEST;
            S_SV_MARK: if (!status.j_lt_ts) state_next = S_SV_TEST;
            S_IDLE:    if (req_valid) state_next = S_DISP;
            S_DISP:    state_next = status.act ? S_G_BND : S_PRIM_CK;
            S_PRIM_CK: state_next = S_DONE;
            S_G_BND:   state_next = status.p_over ? S_DONE : S_G_CKP;
            S_G_CKP:   state_next = status.probe_prime ? S_G_CKF : S_G_BND;
            S_G_CKF:   state_next = status.probe_prime ? S_G_CKS : S_G_BND;
            S_G_CKS:   state_next = status.probe_prime ? S_DONE : S_G_BND;
            S_DONE:    if (out_free) state_next = S_IDLE;
            default:   state_next = S_CLR;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.probe_sel = PR_SIEVE;
        cmd.res_op    = RES_HOLD;
        unique case (state_reg)
            S_CLR:     cmd.clr_step = 1'b1;
            S_SV_INIT: cmd.sv_init = 1'b1;
            S_SV_TEST: cmd.j_load = 1'b1;
            S_SV_CHK:  cmd.i_inc = !status.probe_prime;
            S_SV_MARK:
            begin
                cmd.mark  = status.j_lt_ts;
                cmd.i_inc = !status.j_lt_ts;
            end
            S_IDLE:    cmd.cap = req_valid;
            S_DISP:    cmd.probe_sel = PR_FIRST;
            S_PRIM_CK: cmd.res_op = RES_PRIM;
            S_G_BND:
            begin
                cmd.probe_sel = PR_P;
                if (status.p_over)
                    cmd.res_op = RES_NONE;
            end
            S_G_CKP:
            begin
                cmd.probe_sel = PR_FMP;
                cmd.p_inc     = !status.probe_prime;
            end
            S_G_CKF:
            begin
                cmd.probe_sel = PR_SMP;
                cmd.p_inc     = !status.probe_prime;
            end
            S_G_CKS:
            begin
                cmd.p_inc = !status.probe_prime;
                if (status.probe_prime)
                    cmd.res_op = RES_FOUND;
            end
            S_DONE:    cmd.load_out = out_free;
            default:   cmd.probe_sel = PR_SIEVE;
        endcase
    end

endmodule

[design/psgq_datapath.sv]
module psgq_datapath
    import psgq_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic        action,
    input  logic [15:0] first_value,
    input  logic [15:0] second_value,
    output logic        answer,
    output logic [14:0] shared_prime
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = AW + 1;
    localparam int IW = (AW + 1) / 2 + 1;

    logic mem [TABLE_SIZE];

    logic [AW-1:0] clr_reg;
    logic [IW-1:0] i_reg;
    logic [CW-1:0] sq_reg;
    logic [CW-1:0] j_reg;
    logic          act_reg;
    logic [15:0]   first_reg;
    logic [15:0]   second_reg;
    logic [15:0]   p_reg;
    logic          rd_bit_reg;
    logic          ok_reg;
    logic          res_ans_reg;
    logic [14:0]   res_sp_reg;
    logic          answer_reg;
    logic [14:0]   shared_reg;

    logic [15:0]   probe_val;
    logic          probe_ok;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;

    always_comb
    begin
        case (cmd.probe_sel)
            PR_SIEVE: probe_val = 16'(i_reg);
            PR_FIRST: probe_val = first_reg;
            PR_P:     probe_val = p_reg;
            PR_FMP:   probe_val = first_reg - p_reg;
            PR_SMP:   probe_val = second_reg - p_reg;
            default:  probe_val = p_reg;
        endcase
    end

    assign probe_ok = (probe_val >= 16'd2) && (32'(probe_val) < 32'(TABLE_SIZE));

    always_comb
    begin
        wr_en   = cmd.clr_step || cmd.mark;
        wr_addr = cmd.mark ? j_reg[AW-1:0] : clr_reg;
        wr_data = cmd.mark || (clr_reg < AW'(2));
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_bit_reg <= mem[AW'(probe_val)];
        ok_reg     <= probe_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_step)
            clr_reg <= clr_reg + AW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sv_init)
        begin
            i_reg  <= IW'(2);
            sq_reg <= CW'(4);
        end
        else if (cmd.i_inc)
        begin
            i_reg  <= i_reg + IW'(1);
            sq_reg <= sq_reg + (CW'(i_reg) << 1) + CW'(1);
        end
        if (cmd.j_load)
            j_reg <= sq_reg;
        else if (cmd.mark)
            j_reg <= j_reg + CW'(i_reg);
        if (cmd.cap)
        begin
            act_reg    <= action;
            first_reg  <= first_value;
            second_reg <= second_value;
            p_reg      <= 16'd2;
        end
        else if (cmd.p_inc)
            p_reg <= p_reg + 16'd1;
        case (cmd.res_op)
            RES_PRIM:
            begin
                res_ans_reg <= ok_reg && !rd_bit_reg;
                res_sp_reg  <= '0;
            end
            RES_NONE:
            begin
                res_ans_reg <= 1'b0;
                res_sp_reg  <= '0;
            end
            RES_FOUND:
            begin
                res_ans_reg <= 1'b1;
                res_sp_reg  <= p_reg[14:0];
            end
            default: ;
        endcase
        if (cmd.load_out)
        begin
            answer_reg <= res_ans_reg;
            shared_reg <= res_sp_reg;
        end
    end

    assign status.clr_last    = (32'(clr_reg) == 32'(TABLE_SIZE - 1));
    assign status.sq_lt_ts    = (32'(sq_reg) < 32'(TABLE_SIZE));
    assign status.j_lt_ts     = (32'(j_reg) < 32'(TABLE_SIZE));
    assign status.probe_prime = ok_reg && !rd_bit_reg;
    assign status.p_over      = (p_reg > {1'b0, first_reg[15:1]}) || (p_reg > second_reg);
    assign status.act         = act_reg;

    assign answer       = answer_reg;
    assign shared_prime = shared_reg;

endmodule

[design/prime_sieve_goldbach_query.sv]
// A primality word needs one map read. A pair word walks candidate p upward from 2, reading
//   the map for p, then first - p, then second - p, and stops at the first p whose three reads
//   all find a prime, or once p passes first/2 or second.
// One word at a time: req_stall is high outside idle; the single map read port sets the pace.
// Reset (rst_n, async low): a clear pass over all TABLE_SIZE map entries, then the sieve
//   build; req_stall stays high until the map is built.
module prime_sieve_goldbach_query
    import psgq_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        action,
    input  logic [15:0] first_value,
    input  logic [15:0] second_value,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        answer,
    output logic [14:0] shared_prime
);

    cmd_t    cmd;
    status_t status;

    psgq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    psgq_datapath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .action       (action),
        .first_value  (first_value),
        .second_value (second_value),
        .answer       (answer),
        .shared_prime (shared_prime)
    );

endmodule

[design/psgq_checker.sv]
module psgq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic        action,
    input logic [15:0] first_value,
    input logic [15:0] second_value,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic        answer,
    input logic [14:0] shared_prime
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(answer) && $stable(shared_prime))
        else $error("response word changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous word in flight");

    a_no_answer_no_prime: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !answer |-> shared_prime == 15'd0)
        else $error("shared prime reported without answer");

    a_prime_min: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && shared_prime != 15'd0 |-> answer && shared_prime >= 15'd2)
        else $error("shared prime below two");

endmodule

bind prime_sieve_goldbach_query psgq_checker u_psgq_checker (.*);

[tb/tb_prime_sieve_goldbach_query.sv]
`timescale 1ns / 100ps

module tb_prime_sieve_goldbach_query;
    import psgq_pkg::*;

    localparam int TSIZE = TABLE_SIZE_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 32;
    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int RANDOM_WORDS = 1590;

    localparam logic ACT_PRIME = 1'b0;
    localparam logic ACT_PAIR = 1'b1;

    typedef enum {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY
    } rx_mode_t;

    typedef struct packed {
        logic        asked_pair;
        logic        answer;
        logic [14:0] shared_prime;
    } query_result_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic        action;
    logic [15:0] first_value;
    logic [15:0] second_value;
    logic        rsp_valid;
    logic        rsp_stall;
    logic        answer;
    logic [14:0] shared_prime;

    bit            sieve_marks [TSIZE];
    query_result_t answers_due [$];
    query_result_t due_now;

    int       mismatches;
    int       n_prime_q;
    int       n_pair_hit;
    int       n_pair_miss;
    int       idle_cycles;
    int       burst_left;
    bit       steady_send;
    int       hold_asked;
    int       hold_taken;
    int       hold_left;
    int       mode_left;
    rx_mode_t rx_mode;

    prime_sieve_goldbach_query dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .action       (action),
        .first_value  (first_value),
        .second_value (second_value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .answer       (answer),
        .shared_prime (shared_prime)
    );

    always #4 clk = ~clk;

    function automatic bit in_table_prime(input int n);
        return n >= 2 && n < TSIZE && !sieve_marks[n];
    endfunction

    task automatic build_sieve();
        int i;
        int j;
        sieve_marks[0] = 1'b1;
        sieve_marks[1] = 1'b1;
        for (i = 2; i * i < TSIZE; i++)
        begin
            if (!sieve_marks[i])
            begin
                for (j = i * i; j < TSIZE; j += i)
                    sieve_marks[j] = 1'b1;
            end
        end
    endtask

    function automatic query_result_t predict_query(input logic act, input logic [15:0] fv,
                                                    input logic [15:0] sv);
        query_result_t r;
        int f;
        int s;
        int p;
        f = int'(fv);
        s = int'(sv);
        r.asked_pair = act;
        r.answer = 1'b0;
        r.shared_prime = '0;
        if (act == ACT_PRIME)
            r.answer = in_table_prime(f);
        else
        begin
            for (p = 2; p <= f / 2 && p <= s && !r.answer; p++)
            begin
                if (in_table_prime(p) && in_table_prime(f - p) && s - p >= 2
                    && in_table_prime(s - p))
                begin
                    r.answer = 1'b1;
                    r.shared_prime = p[14:0];
                end
            end
        end
        return r;
    endfunction

    task automatic send_query(input logic act, input logic [15:0] fv, input logic [15:0] sv);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        action <= act;
        first_value <= fv;
        second_value <= sv;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        answers_due.push_back(predict_query(act, fv, sv));
    endtask

    task automatic flag_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    endtask

    // receiver: random stall stretches, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_taken != hold_asked)
        begin
            hold_taken = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(16, 96);
            end
            else
                mode_left--;
            case (rx_mode)
                RX_OPEN:  rsp_stall <= 1'b0;
                RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                default:  rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: answer %0d, shared_prime %0d",
                             answer, shared_prime);
            end
            else
            begin
                due_now = answers_due.pop_front();
                if (answer !== due_now.answer)
                    flag_mismatch("answer", 16'(due_now.answer), 16'(answer));
                if (shared_prime !== due_now.shared_prime)
                    flag_mismatch("shared_prime", 16'(due_now.shared_prime),
                                  16'(shared_prime));
                if (!due_now.asked_pair)
                    n_prime_q++;
                else if (due_now.answer)
                    n_pair_hit++;
                else
                    n_pair_miss++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic test_primality_directed();
        send_query(ACT_PRIME, 16'd0, 16'd0);
        send_query(ACT_PRIME, 16'd1, 16'hFFFF);
        send_query(ACT_PRIME, 16'd2, 16'd0);
        send_query(ACT_PRIME, 16'd3, 16'h5A5A);
        send_query(ACT_PRIME, 16'd4, 16'd0);
        send_query(ACT_PRIME, 16'd65521, 16'd0);
        send_query(ACT_PRIME, 16'd65534, 16'hFFFF);
        send_query(ACT_PRIME, 16'd65535, 16'hFFFF);
        send_query(ACT_PRIME, 16'd32749, 16'd1);
    endtask

    task automatic test_pair_directed();
        send_query(ACT_PAIR, 16'd4, 16'd4);
        send_query(ACT_PAIR, 16'd2, 16'd2);
        send_query(ACT_PAIR, 16'd0, 16'd0);
        send_query(ACT_PAIR, 16'd3, 16'd3);
        send_query(ACT_PAIR, 16'd5, 16'd7);
        send_query(ACT_PAIR, 16'd6, 16'd8);
        send_query(ACT_PAIR, 16'd100, 16'd1);
        send_query(ACT_PAIR, 16'd8, 16'd65535);
        send_query(ACT_PAIR, 16'd65534, 16'd3);
        send_query(ACT_PAIR, 16'd65534, 16'd65534);
        send_query(ACT_PAIR, 16'd40000, 16'd65534);
        // odd first value: only p = 2 can qualify, so the walk runs to the end
        send_query(ACT_PAIR, 16'd65535, 16'd65535);
    endtask

    task automatic test_random_mix();
        int k;
        int sel;
        logic [15:0] fv;
        logic [15:0] sv;
        for (k = 0; k < RANDOM_WORDS; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
            begin
                fv = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 64))
                                                 : 16'($urandom_range(0, 65535));
                sv = 16'($urandom_range(0, 65535));
                send_query(ACT_PRIME, fv, sv);
            end
            else if (sel < 75)
            begin
                if ($urandom_range(0, 32) == 0)
                begin
                    fv = 16'(2 * $urandom_range(2, 32767));
                    sv = 16'(2 * $urandom_range(2, 32767));
                end
                else
                begin
                    fv = 16'(2 * $urandom_range(2, 1500));
                    sv = 16'(2 * $urandom_range(2, 1500));
                end
                send_query(ACT_PAIR, fv, sv);
            end
            else
            begin
                // malformed pairs, kept to a short walk
                if ($urandom_range(0, 1) == 0)
                begin
                    fv = 16'($urandom_range(0, 65535));
                    sv = 16'($urandom_range(0, 300));
                end
                else
                begin
                    fv = 16'($urandom_range(0, 600));
                    sv = 16'($urandom_range(0, 65535));
                end
                send_query(ACT_PAIR, fv, sv);
            end
        end
    endtask

    task automatic test_backpressure();
        int k;
        steady_send = 1'b1;
        hold_asked++;
        for (k = 0; k < 40; k++)
        begin
            if (k[0])
                send_query(ACT_PRIME, 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)));
            else
                send_query(ACT_PAIR, 16'(2 * $urandom_range(2, 200)),
                           16'(2 * $urandom_range(2, 200)));
        end
        steady_send = 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        action = ACT_PRIME;
        first_value = '0;
        second_value = '0;
        rsp_stall = 1'b0;
        build_sieve();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_primality_directed();
        test_pair_directed();
        test_backpressure();
        test_random_mix();

        req_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (answers_due.size() != 0)
        begin
            mismatches += answers_due.size();
            $display("%0d result words never arrived", answers_due.size());
        end
        $display("checked %0d primality words and %0d pair words", n_prime_q,
                 n_pair_hit + n_pair_miss);
        $display("pair words: %0d with a shared prime, %0d without; %0d mismatches",
                 n_pair_hit, n_pair_miss, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[prime_sieve_goldbach_query.f]
design/psgq_pkg.sv
design/psgq_ctrl.sv
design/psgq_datapath.sv
design/prime_sieve_goldbach_query.sv
design/psgq_checker.sv
tb/tb_prime_sieve_goldbach_query.sv
